/* src/can_address_claim_controller_assert.svh */
// ----------------------------------------------------------------------------
// can_address_claim_controller_assert.svh
// assertion macros shared by the address-claim controller modules
// ----------------------------------------------------------------------------
`ifndef CAN_ADDRESS_CLAIM_CONTROLLER_ASSERT_SVH
`define CAN_ADDRESS_CLAIM_CONTROLLER_ASSERT_SVH

`ifndef ASSERT_OFF

// property checked on every clock edge outside reset
`define CACC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// condition that must never be seen outside reset
`define CACC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`else

`define CACC_ASSERT(lbl, clk, rst_n, prop, msg)
`define CACC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* src/cacc_pkg.sv */
// ----------------------------------------------------------------------------
// cacc_pkg
// types and constants of the address-claim controller
// ----------------------------------------------------------------------------
package cacc_pkg;

	localparam int unsigned MaxPreferred = 8;
	localparam int unsigned IdxW = $clog2(MaxPreferred);
	localparam int unsigned CntW = IdxW + 1;

	localparam logic [7:0]  ADDR_INVALID   = 8'd254;
	localparam logic [7:0]  ADDR_BROADCAST = 8'd255;
	localparam logic [17:0] CLAIM_GROUP    = 18'h0EE00;
	localparam logic [15:0] TIMEOUT_RESET  = 16'd250;

	// input opcodes
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_START   = 2'd1;
	localparam logic [1:0] OP_CLAIM   = 2'd2;
	localparam logic [1:0] OP_REQUEST = 2'd3;

	// result kinds
	localparam logic KIND_CLAIM   = 1'b0;
	localparam logic KIND_ADDRESS = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_OWN_NAME  = 2'd0;
	localparam logic [1:0] REG_PREF_ADDR = 2'd1;
	localparam logic [1:0] REG_PREF_CNT  = 2'd2;
	localparam logic [1:0] REG_TIMEOUT   = 2'd3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  src_address;
		logic [7:0]  dst_address;
		logic [63:0] peer_name;
		logic [17:0] requested_group;
	} item_t;

	typedef struct packed {
		logic [63:0]     own_name;
		logic [63:0]     pref_addrs;
		logic [CntW-1:0] eff_count;
		logic [15:0]     timeout;
	} cfg_t;

	// up to two results of one item
	typedef struct packed {
		logic [1:0] n;
		logic       kind0;
		logic [7:0] addr0;
		logic       kind1;
		logic [7:0] addr1;
	} res_t;

endpackage

/* src/cacc_item_if.sv */
// ----------------------------------------------------------------------------
// cacc_item_if
// input channel: received frames, ticks and start commands
// ----------------------------------------------------------------------------
interface cacc_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  src_address;
	logic [7:0]  dst_address;
	logic [63:0] peer_name;
	logic [17:0] requested_group;

	modport source (
		output valid, opcode, src_address, dst_address, peer_name, requested_group,
		input  ready
	);
	modport sink (
		input  valid, opcode, src_address, dst_address, peer_name, requested_group,
		output ready
	);
endinterface

/* src/cacc_result_if.sv */
// ----------------------------------------------------------------------------
// cacc_result_if
// output channel: claim frames to send and held address changes
// ----------------------------------------------------------------------------
interface cacc_result_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] address;
	logic       last;

	modport source (
		output valid, kind, address, last,
		input  ready
	);
	modport sink (
		input  valid, kind, address, last,
		output ready
	);
endinterface

/* src/cacc_cfg.sv */
// ----------------------------------------------------------------------------
// cacc_cfg
// configuration registers and effective preferred-list length
// ----------------------------------------------------------------------------
module cacc_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	output cacc_pkg::cfg_t      cfg
);

	logic [63:0] own_name_q;
	logic [63:0] pref_addrs_q;
	logic [3:0]  pref_cnt_q;
	logic [15:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_name_q   <= '0;
			pref_addrs_q <= '0;
			pref_cnt_q   <= 4'd1;
			timeout_q    <= cacc_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cacc_pkg::REG_OWN_NAME:  own_name_q   <= cfg_data;
				cacc_pkg::REG_PREF_ADDR: pref_addrs_q <= cfg_data;
				cacc_pkg::REG_PREF_CNT:  pref_cnt_q   <= cfg_data[3:0];
				cacc_pkg::REG_TIMEOUT:   timeout_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, anything above the list size saturates
	always_comb begin
		cfg.own_name   = own_name_q;
		cfg.pref_addrs = pref_addrs_q;
		cfg.timeout    = timeout_q;
		if (pref_cnt_q == 4'd0)
			cfg.eff_count = cacc_pkg::CntW'(1);
		else if (pref_cnt_q > 4'(cacc_pkg::MaxPreferred))
			cfg.eff_count = cacc_pkg::CntW'(cacc_pkg::MaxPreferred);
		else
			cfg.eff_count = pref_cnt_q[cacc_pkg::CntW-1:0];
	end

endmodule

/* src/cacc_core.sv */
// ----------------------------------------------------------------------------
// cacc_core
// claim state and its combinational update for one item
// ----------------------------------------------------------------------------
`include "can_address_claim_controller_assert.svh"

module cacc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  cacc_pkg::item_t     item,
	input  cacc_pkg::cfg_t      cfg,
	output cacc_pkg::res_t      res
);

	localparam logic [1:0] PH_IDLE     = 2'd0;
	localparam logic [1:0] PH_CLAIMING = 2'd1;
	localparam logic [1:0] PH_HOLDING  = 2'd2;

	localparam int unsigned IdxW = cacc_pkg::IdxW;
	localparam int unsigned CntW = cacc_pkg::CntW;

	logic [1:0]      phase_q, phase_d;
	logic [7:0]      held_q, held_d;
	logic [7:0]      cand_q, cand_d;
	logic [IdxW-1:0] rot_q, rot_d;
	logic [3:0]      att_q, att_d;
	logic [15:0]     wait_q, wait_d;

	logic [IdxW-1:0] idx;
	logic [CntW-1:0] idx_inc;
	logic [IdxW-1:0] rot_adv;
	logic [7:0]      next_addr;
	logic            name_wins;
	logic            do_start;
	logic            do_next;
	logic [3:0]      att_base;

	always_comb begin
		idx       = ({1'b0, rot_q} >= cfg.eff_count) ? '0 : rot_q;
		idx_inc   = {1'b0, idx} + CntW'(1);
		rot_adv   = (idx_inc >= cfg.eff_count) ? '0 : idx_inc[IdxW-1:0];
		next_addr = cfg.pref_addrs[{idx, 3'b000} +: 8];
		name_wins = cfg.own_name < item.peer_name;
	end

	always_comb begin
		phase_d  = phase_q;
		held_d   = held_q;
		cand_d   = cand_q;
		rot_d    = rot_q;
		att_d    = att_q;
		wait_d   = wait_q;
		res      = '0;
		do_start = 1'b0;
		do_next  = 1'b0;

		if (item.opcode == cacc_pkg::OP_START) begin
			do_start = 1'b1;
		end else if (phase_q == PH_CLAIMING) begin
			if (item.opcode == cacc_pkg::OP_TICK) begin
				if (wait_q <= 16'd1) begin
					wait_d    = '0;
					held_d    = cand_q;
					phase_d   = PH_HOLDING;
					res.n     = 2'd1;
					res.kind0 = cacc_pkg::KIND_ADDRESS;
					res.addr0 = cand_q;
				end else begin
					wait_d = wait_q - 16'd1;
				end
			end else if (item.opcode == cacc_pkg::OP_CLAIM) begin
				if (item.src_address == cand_q) begin
					if (name_wins) begin
						wait_d    = cfg.timeout;
						res.n     = 2'd1;
						res.kind0 = cacc_pkg::KIND_CLAIM;
						res.addr0 = cand_q;
					end else if (4'(cfg.eff_count) > att_q) begin
						do_next = 1'b1;
					end else begin
						// every address lost: cannot-claim frame
						phase_d   = PH_HOLDING;
						held_d    = cacc_pkg::ADDR_INVALID;
						res.n     = 2'd1;
						res.kind0 = cacc_pkg::KIND_CLAIM;
						res.addr0 = cacc_pkg::ADDR_INVALID;
					end
				end else begin
					wait_d = cfg.timeout;
				end
			end
		end else if (phase_q == PH_HOLDING) begin
			if (item.opcode == cacc_pkg::OP_REQUEST) begin
				if (item.requested_group == cacc_pkg::CLAIM_GROUP &&
					(item.dst_address == cacc_pkg::ADDR_BROADCAST ||
					item.dst_address == held_q)) begin
					res.n     = 2'd1;
					res.kind0 = cacc_pkg::KIND_CLAIM;
					res.addr0 = held_q;
				end
			end else if (item.opcode == cacc_pkg::OP_CLAIM) begin
				if (item.src_address != cacc_pkg::ADDR_INVALID &&
					item.src_address == held_q) begin
					if (name_wins) begin
						res.n     = 2'd1;
						res.kind0 = cacc_pkg::KIND_CLAIM;
						res.addr0 = held_q;
					end else begin
						do_start = 1'b1;
					end
				end
			end
		end

		// restart: report invalid address, then claim the next candidate; next: claim it alone
		att_base = do_start ? 4'd0 : att_q;
		if (do_start) begin
			held_d    = cacc_pkg::ADDR_INVALID;
			res.n     = 2'd2;
			res.kind0 = cacc_pkg::KIND_ADDRESS;
			res.addr0 = cacc_pkg::ADDR_INVALID;
			res.kind1 = cacc_pkg::KIND_CLAIM;
			res.addr1 = next_addr;
		end else if (do_next) begin
			res.n     = 2'd1;
			res.kind0 = cacc_pkg::KIND_CLAIM;
			res.addr0 = next_addr;
		end
		if (do_start || do_next) begin
			cand_d  = next_addr;
			rot_d   = rot_adv;
			att_d   = att_base + 4'd1;
			wait_d  = cfg.timeout;
			phase_d = PH_CLAIMING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= cacc_pkg::ADDR_INVALID;
			cand_q  <= '0;
			rot_q   <= '0;
			att_q   <= '0;
			wait_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			cand_q  <= cand_d;
			rot_q   <= rot_d;
			att_q   <= att_d;
			wait_q  <= wait_d;
		end
	end

	`CACC_ASSERT_NEVER(a_phase_code, clk, arst_n, phase_q == 2'd3, "unused phase code reached")
	`CACC_ASSERT(a_idle_invalid, clk, arst_n, (phase_q == PH_IDLE) |-> (held_q == cacc_pkg::ADDR_INVALID), "idle with a held address")
	`CACC_ASSERT(a_held_on_fire, clk, arst_n, !$stable(held_q) |-> $past(fire), "held address changed without an item")

endmodule

/* src/cacc_out.sv */
// ----------------------------------------------------------------------------
// cacc_out
// two-entry result register that drains one beat per cycle while ready is high
// ----------------------------------------------------------------------------
`include "can_address_claim_controller_assert.svh"

module cacc_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  cacc_pkg::res_t      res,
	output logic                room,
	cacc_result_if.source       result
);

	logic [1:0] cnt_q;
	logic       kind0_q, kind1_q;
	logic [7:0] addr0_q, addr1_q;
	logic       pop;

	assign pop  = result.valid && result.ready;
	// a new item may load only once the previous one's beats are gone
	assign room = (cnt_q == 2'd0) || (cnt_q == 2'd1 && result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= res.n;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind0_q <= res.kind0;
			addr0_q <= res.addr0;
			kind1_q <= res.kind1;
			addr1_q <= res.addr1;
		end else if (pop) begin
			kind0_q <= kind1_q;
			addr0_q <= addr1_q;
		end
	end

	assign result.valid   = cnt_q != 2'd0;
	assign result.kind    = kind0_q;
	assign result.address = addr0_q;
	assign result.last    = cnt_q == 2'd1;

	`CACC_ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q == 2'd3, "result count overflow")
	`CACC_ASSERT(a_pair_loaded, clk, arst_n, (load && res.n == 2'd2) |=> (cnt_q == 2'd2), "result pair not stored")
	`CACC_ASSERT(a_pair_held, clk, arst_n, (cnt_q == 2'd2 && !result.ready) |=> (cnt_q == 2'd2), "stalled result pair lost")

endmodule

/* src/can_address_claim_controller.sv */
// ----------------------------------------------------------------------------
// can_address_claim_controller
// address-claim node: claims, holds and defends a network address
// ----------------------------------------------------------------------------
// An input beat lands in an input register and is worked through
// combinationally into a two-entry result register, from which the result
// beats are offered. One input beat is taken every cycle while results are
// taken as they appear. A start, or a lost defense while holding, gives two
// result beats (invalid address, then the claim); the result register drains
// one beat per cycle while results are taken, so the input after such an item
// waits until the first of its beats has gone. Configuration writes go
// straight to registers and take effect on the next item.
module can_address_claim_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [63:0]   cfg_data,
	cacc_item_if.sink     item,
	cacc_result_if.source result
);

	cacc_pkg::item_t item_s1;
	logic            valid_s1;
	logic            fire;
	logic            room;
	cacc_pkg::cfg_t  cfg;
	cacc_pkg::res_t  res;

	assign fire       = valid_s1 && room;
	assign item.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.opcode          <= item.opcode;
			item_s1.src_address     <= item.src_address;
			item_s1.dst_address     <= item.dst_address;
			item_s1.peer_name       <= item.peer_name;
			item_s1.requested_group <= item.requested_group;
		end
	end

	cacc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cacc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	cacc_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire),
		.res    (res),
		.room   (room),
		.result (result)
	);

endmodule
